[hw/rtl/daes_pkg.sv]
// ----------------------------------------------------------------------------
// daes_pkg
// Shared types, codes and constants of the daily alarm escalation scheduler.
// ----------------------------------------------------------------------------
package daes_pkg;

  // default number of alarm slots
  localparam int SLOT_COUNT_DEF = 4;

  // field widths
  localparam int SEC_W    = 17;
  localparam int WORD_W   = 44;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int TMO_W    = 16;
  localparam int LEVEL_W  = 2;
  localparam int KIND_W   = 2;
  localparam int EVSLOT_W = 2;
  localparam int BLINK_W  = 10;
  localparam int HZ_W     = 11;
  localparam int APB_W    = 64;

  // slot word layout
  localparam int HOUR_LSB = 0;
  localparam int MIN_LSB  = 5;
  localparam int EN_BIT   = 11;
  localparam int ESC_LSB  = 12;
  localparam int MISS_LSB = 28;

  // time constants
  localparam int SEC_PER_HOUR = 3600;
  localparam int SEC_PER_MIN  = 60;
  localparam int HOUR_MAX     = 23;
  localparam int MIN_MAX      = 59;
  localparam logic [TMO_W-1:0] ESC_DEFAULT = TMO_W'(30);
  localparam logic [TMO_W-1:0] MISS_EXTRA  = TMO_W'(60);

  // indicator settings
  localparam logic [BLINK_W-1:0] BLINK_ACTIVE_MS = BLINK_W'(1000);
  localparam logic [BLINK_W-1:0] BLINK_ESC_MS    = BLINK_W'(300);
  localparam logic [HZ_W-1:0]    BUZZ_ACTIVE_HZ  = HZ_W'(1200);
  localparam logic [HZ_W-1:0]    BUZZ_ESC_HZ     = HZ_W'(2000);

  // alert levels
  typedef enum logic [LEVEL_W-1:0] {
    LEVEL_IDLE      = 2'd0,
    LEVEL_ACTIVE    = 2'd1,
    LEVEL_ESCALATED = 2'd2
  } level_t;

  // event codes
  typedef enum logic [KIND_W-1:0] {
    EV_NONE    = 2'd0,
    EV_ON_TIME = 2'd1,
    EV_LATE    = 2'd2,
    EV_MISSED  = 2'd3
  } event_t;

  // per-tick control broadcast to every cell
  typedef struct packed {
    logic             fire_en;   // word accepted while no alert runs
    logic             day_roll;  // word accepted with a drop in second of day
    logic [SEC_W-1:0] now;
  } cell_ctl_t;

  // what a cell reports about its slot
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [SEC_W-1:0]  at_second;
    logic [TMO_W-1:0]  esc;
    logic [TMO_W-1:0]  miss;
    logic              take;
  } cell_stat_t;

endpackage

[hw/rtl/daily_alarm_escalation_scheduler_core.sv]
// ----------------------------------------------------------------------------
// daily_alarm_escalation_scheduler_core
// An accepted input word gives its result word through the output register.
// Throughput: one word per cycle unless in_stall is raised; a row of slot
// cells settles the priority select and the alert timer in the same cycle.
// Reset: synchronous; clears slot words, fired marks, alert state, output.
// ----------------------------------------------------------------------------
module daily_alarm_escalation_scheduler_core #(
  parameter int SLOT_COUNT = daes_pkg::SLOT_COUNT_DEF,
  parameter int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  parameter int ADDR_W     = IDX_W + 3
) (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [daes_pkg::SEC_W-1:0]    now_second,
  input  logic                          ack_button,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          led_lit,
  output logic                          led_blinking,
  output logic [daes_pkg::BLINK_W-1:0]  blink_period_ms,
  output logic                          buzzer_sounding,
  output logic [daes_pkg::HZ_W-1:0]     buzzer_hz,
  output logic [daes_pkg::LEVEL_W-1:0]  alert_level,
  output logic [daes_pkg::KIND_W-1:0]   event_kind,
  output logic [daes_pkg::EVSLOT_W-1:0] event_slot,
  output logic [daes_pkg::SEC_W-1:0]    event_second,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [daes_pkg::APB_W-1:0]    pwdata,
  output logic [daes_pkg::APB_W-1:0]    prdata,
  output logic                          pready
);
  import daes_pkg::*;

  logic                  accept;
  logic                  cfg_wr;
  logic [IDX_W-1:0]      cfg_idx;
  logic                  cfg_hit;
  cell_ctl_t             ctl;
  cell_stat_t            stat [SLOT_COUNT];
  logic [SLOT_COUNT:0]   claim;

  // alert state
  logic                  busy;
  logic [IDX_W-1:0]      alert_idx;
  logic [SEC_W-1:0]      due_second;
  level_t                level;
  logic [SEC_W-1:0]      previous_second;

  logic                  busy_next;
  logic [IDX_W-1:0]      alert_idx_next;
  logic [SEC_W-1:0]      due_second_next;
  level_t                level_next;
  event_t                kind_next;

  logic [IDX_W-1:0]      take_idx;
  logic [SEC_W-1:0]      elapsed;
  logic [TMO_W-1:0]      alert_esc;
  logic [TMO_W-1:0]      alert_miss;

  // output register
  level_t                out_level;
  event_t                out_kind;
  logic [IDX_W-1:0]      out_slot;
  logic [SEC_W-1:0]      out_second;

  // handshakes
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign cfg_idx  = paddr[ADDR_W-1:3];
  assign cfg_hit  = (32'(cfg_idx) < SLOT_COUNT);
  assign cfg_wr   = psel && penable && pwrite && cfg_hit;

  // control broadcast to the row
  assign ctl.fire_en  = accept && !busy;
  assign ctl.day_roll = accept && (now_second < previous_second);
  assign ctl.now      = now_second;

  // row of slot cells, claim passes from slot 0 upwards
  assign claim[0] = 1'b0;
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    daes_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr_en     (cfg_wr && (cfg_idx == IDX_W'(g))),
      .wr_data   (pwdata[WORD_W-1:0]),
      .ctl       (ctl),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .stat      (stat[g])
    );
  end

  // register read back
  assign prdata = cfg_hit ? APB_W'(stat[cfg_idx].word) : '0;

  // index of the slot that fires
  always_comb begin
    take_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (stat[i].take) begin
        take_idx = IDX_W'(i);
      end
    end
  end

  // timeouts and elapsed time of the running alert
  assign alert_esc  = stat[alert_idx].esc;
  assign alert_miss = stat[alert_idx].miss;
  assign elapsed    = (now_second >= due_second) ? (now_second - due_second) : '0;

  // alert state update
  always_comb begin
    busy_next       = busy;
    alert_idx_next  = alert_idx;
    due_second_next = due_second;
    level_next      = level;
    kind_next       = EV_NONE;
    if (busy) begin
      if (ack_button || (elapsed >= SEC_W'(alert_miss))) begin
        if (!ack_button) begin
          kind_next = EV_MISSED;
        end else if (elapsed <= SEC_W'(alert_esc)) begin
          kind_next = EV_ON_TIME;
        end else begin
          kind_next = EV_LATE;
        end
        busy_next       = 1'b0;
        alert_idx_next  = '0;
        due_second_next = '0;
        level_next      = LEVEL_IDLE;
      end else if (elapsed >= SEC_W'(alert_esc)) begin
        level_next = LEVEL_ESCALATED;
      end else begin
        level_next = LEVEL_ACTIVE;
      end
    end else if (claim[SLOT_COUNT]) begin
      busy_next       = 1'b1;
      alert_idx_next  = take_idx;
      due_second_next = stat[take_idx].at_second;
      level_next      = LEVEL_ACTIVE;
    end
  end

  // alert state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy            <= 1'b0;
      alert_idx       <= '0;
      due_second      <= '0;
      level           <= LEVEL_IDLE;
      previous_second <= '0;
    end else if (accept) begin
      busy            <= busy_next;
      alert_idx       <= alert_idx_next;
      due_second      <= due_second_next;
      level           <= level_next;
      previous_second <= now_second;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      out_level  <= LEVEL_IDLE;
      out_kind   <= EV_NONE;
      out_slot   <= '0;
      out_second <= '0;
    end else if (accept) begin
      out_valid  <= 1'b1;
      out_level  <= level_next;
      out_kind   <= kind_next;
      out_slot   <= (kind_next == EV_NONE) ? '0 : alert_idx;
      out_second <= (kind_next == EV_NONE) ? '0 : now_second;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // indicator decode of the output word
  always_comb begin
    unique case (out_level)
      LEVEL_ACTIVE: begin
        blink_period_ms = BLINK_ACTIVE_MS;
        buzzer_hz       = BUZZ_ACTIVE_HZ;
      end
      LEVEL_ESCALATED: begin
        blink_period_ms = BLINK_ESC_MS;
        buzzer_hz       = BUZZ_ESC_HZ;
      end
      default: begin
        blink_period_ms = '0;
        buzzer_hz       = '0;
      end
    endcase
  end

  assign led_lit         = (out_level != LEVEL_IDLE);
  assign led_blinking    = (out_level != LEVEL_IDLE);
  assign buzzer_sounding = (out_level != LEVEL_IDLE);
  assign alert_level     = out_level;
  assign event_kind      = out_kind;
  assign event_slot      = EVSLOT_W'(out_slot);
  assign event_second    = out_second;

endmodule

[hw/rtl/daes_cell.sv]
// ----------------------------------------------------------------------------
// daes_cell
// One alarm slot: holds its word and fired mark, checks whether it is due and
// passes the claim along the row so that the lowest due slot wins.
// ----------------------------------------------------------------------------
module daes_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      wr_en,
  input  logic [daes_pkg::WORD_W-1:0] wr_data,
  input  daes_pkg::cell_ctl_t       ctl,
  input  logic                      claim_in,
  output logic                      claim_out,
  output daes_pkg::cell_stat_t      stat
);
  import daes_pkg::*;

  logic [WORD_W-1:0] word;
  logic              fired;
  logic              fired_next;
  logic [HOUR_W-1:0] hour;
  logic [MIN_W-1:0]  minute;
  logic              usable;
  logic              fired_eff;
  logic              due;
  logic [SEC_W-1:0]  at_second;
  logic [TMO_W-1:0]  esc_raw;
  logic [TMO_W-1:0]  miss_raw;
  logic [TMO_W-1:0]  esc;
  logic [TMO_W-1:0]  miss;

  // decode the slot word
  assign hour     = word[HOUR_LSB +: HOUR_W];
  assign minute   = word[MIN_LSB +: MIN_W];
  assign esc_raw  = word[ESC_LSB +: TMO_W];
  assign miss_raw = word[MISS_LSB +: TMO_W];
  assign usable   = word[EN_BIT] && (hour <= HOUR_W'(HOUR_MAX))
                    && (minute <= MIN_W'(MIN_MAX));

  // alarm time of day
  assign at_second = SEC_W'(hour * SEC_W'(SEC_PER_HOUR))
                   + SEC_W'(minute * SEC_W'(SEC_PER_MIN));

  // timeout defaults
  assign esc  = (esc_raw == '0) ? ESC_DEFAULT : esc_raw;
  assign miss = (miss_raw <= esc) ? (esc + MISS_EXTRA) : miss_raw;

  // due check, with the fired mark as seen after a day roll
  assign fired_eff = fired && !ctl.day_roll;
  assign due       = usable && !fired_eff && (ctl.now >= at_second);
  assign claim_out = claim_in || due;

  assign stat.word      = word;
  assign stat.at_second = at_second;
  assign stat.esc       = esc;
  assign stat.miss      = miss;
  assign stat.take      = ctl.fire_en && due && !claim_in;

  // fired mark update
  always_comb begin
    priority if (wr_en) begin
      fired_next = 1'b0;
    end else if (stat.take) begin
      fired_next = 1'b1;
    end else if (ctl.day_roll) begin
      fired_next = 1'b0;
    end else begin
      fired_next = fired;
    end
  end

  // slot registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word  <= '0;
      fired <= 1'b0;
    end else begin
      if (wr_en) begin
        word <= wr_data;
      end
      fired <= fired_next;
    end
  end

endmodule
